// ===== sv/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants and types for the masked byte pattern search core.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_PATTERN_BYTES = 32;
	localparam int OFFSET_BITS       = 24;
	localparam int COUNT_BITS        = OFFSET_BITS + 1;
	localparam int LEN_BITS          = $clog2(MAX_PATTERN_BYTES + 1);

	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_INDEX_BITS = 3;
	localparam int PLEN_BITS      = 6;
	localparam int MASK_BITS      = 32;
	localparam int PAT_WORDS      = 4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD0  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD1  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD2  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD3  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COMPARE_MASK   = 3'd5;

	typedef struct packed {
		logic                   found;
		logic [OFFSET_BITS-1:0] offset;
	} result_t;

endpackage

// ===== sv/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte of the search chain with its masked compare.
// ----------------------------------------------------------------------------
module mbps_cell (
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] byte_in,
	input  logic [7:0] pat_byte,
	input  logic       cmp_en,
	output logic [7:0] byte_out,
	output logic       hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	// compare against the byte that enters this cell
	assign hit      = !cmp_en || (byte_in == pat_byte);
	assign byte_out = byte_q;

endmodule

// ===== sv/mbps_out_buf.sv =====
// ----------------------------------------------------------------------------
// mbps_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module mbps_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mbps_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output mbps_pkg::result_t out_data
);
	import mbps_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    take;

	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || take) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sv/masked_byte_pattern_search_core.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_core
// Streams a buffer one byte per transaction through a chain of window cells
// and reports the first offset where the masked pattern matches.
// ----------------------------------------------------------------------------
//  channel  signals                          direction
//  input    in_valid in_stall data_byte ...  byte in, last_byte ends buffer
//  output   out_valid out_stall found ...    one result per buffer
//  config   cfg_we cfg_index cfg_data        register write, no read-back
//
//  one byte per cycle while not stalled; the cells shift on each accepted
//  byte, compares and offset subtract are combinational, and the result is
//  registered into a two-entry output buffer that lets input continue while
//  a result is held; input stalls only when both entries are full.
//  reset clears count, found flag and buffer valids; no clearing pass.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mbps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mbps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            data_byte,
	input  logic                                  last_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	output logic [mbps_pkg::OFFSET_BITS-1:0]      match_offset
);
	import mbps_pkg::*;

	localparam int WIN_BITS = MAX_PATTERN_BYTES * 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [PLEN_BITS-1:0]     pattern_length_q;
	logic [CFG_DATA_BITS-1:0] pattern_word_q [PAT_WORDS];
	logic [MASK_BITS-1:0]     compare_mask_q;

	logic [COUNT_BITS-1:0] count_q;
	logic                  done_q;

	logic [LEN_BITS-1:0]          eff_len;
	logic [LEN_BITS-1:0]          shamt;
	logic [PAT_WORDS*CFG_DATA_BITS-1:0] pat_all;
	logic [WIN_BITS-1:0]          aligned_pat;
	logic [MAX_PATTERN_BYTES-1:0] len_ones;
	logic [MAX_PATTERN_BYTES-1:0] aligned_mask;

	logic [7:0]                   cell_byte [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] cell_hit;

	logic                  accept;
	logic [COUNT_BITS-1:0] count_n;
	logic [COUNT_BITS-1:0] start;
	logic                  match;
	logic                  push;
	result_t               push_data;
	result_t               out_data;
	logic                  buf_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= PLEN_BITS'(1);
			for (int w = 0; w < PAT_WORDS; w++) begin
				pattern_word_q[w] <= '0;
			end
			compare_mask_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[PLEN_BITS-1:0];
				REG_PATTERN_WORD0:  pattern_word_q[0] <= cfg_data;
				REG_PATTERN_WORD1:  pattern_word_q[1] <= cfg_data;
				REG_PATTERN_WORD2:  pattern_word_q[2] <= cfg_data;
				REG_PATTERN_WORD3:  pattern_word_q[3] <= cfg_data;
				REG_COMPARE_MASK:   compare_mask_q <= cfg_data[MASK_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective length and pattern aligned to the newest window byte
	always_comb begin
		priority if (pattern_length_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (pattern_length_q > PLEN_BITS'(MAX_PATTERN_BYTES)) begin
			eff_len = LEN_BITS'(MAX_PATTERN_BYTES);
		end else begin
			eff_len = LEN_BITS'(pattern_length_q);
		end
	end

	assign shamt = LEN_BITS'(MAX_PATTERN_BYTES) - eff_len;

	always_comb begin
		for (int w = 0; w < PAT_WORDS; w++) begin
			pat_all[w*CFG_DATA_BITS +: CFG_DATA_BITS] = pattern_word_q[w];
		end
	end

	assign aligned_pat  = pat_all[WIN_BITS-1:0] << {shamt, 3'b000};
	assign len_ones     = {MAX_PATTERN_BYTES{1'b1}} >> shamt;
	assign aligned_mask = (compare_mask_q[MAX_PATTERN_BYTES-1:0] & len_ones) << shamt;

	assign accept = in_valid && !in_stall;

	// window chain, newest byte enters the top cell
	for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
		logic [7:0] cell_in;
		if (k == MAX_PATTERN_BYTES - 1) begin : g_top
			assign cell_in = data_byte;
		end else begin : g_mid
			assign cell_in = cell_byte[k+1];
		end
		mbps_cell u_cell (
			.clk      (clk),
			.shift_en (accept),
			.byte_in  (cell_in),
			.pat_byte (aligned_pat[k*8 +: 8]),
			.cmp_en   (aligned_mask[k]),
			.byte_out (cell_byte[k]),
			.hit      (cell_hit[k])
		);
	end

	assign count_n = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
	assign start   = count_n - COUNT_BITS'(eff_len);
	assign match   = !done_q && (count_n >= COUNT_BITS'(eff_len))
		&& !start[COUNT_BITS-1] && (&cell_hit);

	assign push = accept && !done_q && (match || last_byte);
	assign push_data.found  = match;
	assign push_data.offset = match ? start[OFFSET_BITS-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				done_q  <= 1'b0;
			end else if (!done_q) begin
				count_q <= count_n;
				done_q  <= match;
			end
		end
	end

	mbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign in_stall     = buf_full;
	assign found        = out_data.found;
	assign match_offset = out_data.offset;

	// full buffer implies a result is presented
	a_full_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> out_valid)
		else $error("skid entry held without output entry");

	// no result between a match and the end of its buffer
	a_quiet_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && accept) |-> !push)
		else $error("result after match in same buffer");

	// a match leaves the found flag set unless the buffer ended
	a_done_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.found && !last_byte) |=> done_q)
		else $error("found flag not set after match");

	// a buffer end always clears the search state
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (!done_q && count_q == '0))
		else $error("state not cleared at end of buffer");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for masked_byte_pattern_search_core. Byte buffers with
// planted, partial and broken copies of the masked pattern stream in under
// random gaps and output stalls. A scoreboard keeps its own copy of the
// window, byte count and configuration, predicts the single result of each
// buffer and compares it with what the core reports.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mbps_pkg::*;

	localparam int N_ITEMS       = 950;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 3000;

	class search_scoreboard;
		logic [PLEN_BITS-1:0]     plen;
		logic [CFG_DATA_BITS-1:0] pat_word [PAT_WORDS];
		logic [MASK_BITS-1:0]     byte_mask;
		logic [7:0]               window [MAX_PATTERN_BYTES];
		logic [COUNT_BITS-1:0]    seen;
		logic                     hit_done;
		result_t                  hits_due [$];
		int                       errors;

		function new();
			plen = 1;
			foreach (pat_word[i]) pat_word[i] = '0;
			byte_mask = '1;
			errors = 0;
			clear_buffer();
		endfunction

		function void clear_buffer();
			foreach (window[i]) window[i] = 8'h00;
			seen = '0;
			hit_done = 1'b0;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
			case (idx)
				REG_PATTERN_LENGTH: plen = v[PLEN_BITS-1:0];
				REG_PATTERN_WORD0, REG_PATTERN_WORD1, REG_PATTERN_WORD2,
				REG_PATTERN_WORD3: pat_word[idx - REG_PATTERN_WORD0] = v;
				REG_COMPARE_MASK: byte_mask = v[MASK_BITS-1:0];
				default: ;
			endcase
		endfunction

		function int eff_len();
			int n;
			n = plen;
			if (n == 0) n = 1;
			if (n > MAX_PATTERN_BYTES) n = MAX_PATTERN_BYTES;
			return n;
		endfunction

		function logic [7:0] pattern_byte(int i);
			return pat_word[i / 8][8 * (i % 8) +: 8];
		endfunction

		// returns 1 when the core still looks at the byte
		function bit note_byte(logic [7:0] b, logic lst);
			int len;
			logic [COUNT_BITS-1:0] start;
			bit hit;
			bit used;
			bit match;
			result_t r;
			len = eff_len();
			hit = 1'b0;
			used = !hit_done;
			if (!hit_done) begin
				for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) window[i] = window[i + 1];
				window[MAX_PATTERN_BYTES - 1] = b;
				if (seen != '1) seen++;
				if (seen >= len) begin
					start = seen - COUNT_BITS'(len);
					match = 1'b1;
					for (int i = 0; i < len; i++)
						if (byte_mask[i] && pattern_byte(i) != window[MAX_PATTERN_BYTES - len + i])
							match = 1'b0;
					if (!start[OFFSET_BITS] && match) begin
						hit = 1'b1;
						hit_done = 1'b1;
						r.found = 1'b1;
						r.offset = start[OFFSET_BITS-1:0];
						hits_due.push_back(r);
					end
				end
				if (lst && !hit) begin
					r.found = 1'b0;
					r.offset = '0;
					hits_due.push_back(r);
				end
			end
			if (lst) clear_buffer();
			return used;
		endfunction

		function void check_result(logic f, logic [OFFSET_BITS-1:0] off);
			result_t want;
			if (hits_due.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: expected none, actual found=%0b offset=%0d",
					$time, f, off);
				return;
			end
			want = hits_due.pop_front();
			if (f !== want.found) begin
				errors++;
				$display("%0t found: expected %0b, actual %0b", $time, want.found, f);
			end
			if (off !== want.offset) begin
				errors++;
				$display("%0t match_offset: expected %0d, actual %0d", $time, want.offset, off);
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic [7:0]                data_byte = 8'h00;
	logic                      last_byte = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      found;
	logic [OFFSET_BITS-1:0]    match_offset;

	search_scoreboard sb = new();
	logic [7:0] byte_buf [$];
	bit idle_in = 1'b1;
	bit idle_out = 1'b1;
	int live_bytes = 0;
	int stall_left = 3;
	int quiet_cycles = 0;

	masked_byte_pattern_search_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.match_offset(match_offset)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic set_config(input logic [63:0] len_v, input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3, input logic [63:0] mask_v);
		write_reg(REG_PATTERN_LENGTH, len_v);
		write_reg(REG_PATTERN_WORD0, w0);
		write_reg(REG_PATTERN_WORD1, w1);
		write_reg(REG_PATTERN_WORD2, w2);
		write_reg(REG_PATTERN_WORD3, w3);
		write_reg(REG_COMPARE_MASK, mask_v);
		cfg_we <= 1'b0;
	endtask

	task automatic send_buffer();
		int gap;
		bit lst;
		for (int k = 0; k < byte_buf.size(); k++) begin
			gap = idle_in ? $urandom_range(0, 11) : 0;
			lst = (k == byte_buf.size() - 1);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid  <= 1'b1;
			data_byte <= byte_buf[k];
			last_byte <= lst;
			do @(posedge clk); while (in_stall);
			void'(sb.note_byte(byte_buf[k], lst));
			live_bytes++;
		end
	endtask

	// hold the sender until every result is out, then let the core go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.hits_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_result(found, match_offset);
				stall_left = idle_out ? $urandom_range(0, 11) : 0;
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int len;
		int blen;
		int pos;
		logic [63:0] len_v;
		logic [63:0] mask_v;
		logic [63:0] pw [PAT_WORDS];

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one zero byte, fully compared
		byte_buf = '{8'hFF, 8'h00, 8'h12};
		send_buffer();
		byte_buf = '{8'hFF};
		send_buffer();
		settle();

		// short buffer, then a match on the last byte
		set_config(64'd3, 64'h0000_0000_00CC_BBAA, 64'd0, 64'd0, 64'd0, 64'hFFFF_FFFF);
		byte_buf = '{8'hAA, 8'hBB};
		send_buffer();
		byte_buf = '{8'h11, 8'hAA, 8'hBB, 8'hCC};
		send_buffer();
		settle();

		// length zero acts as one
		set_config(64'h40, 64'h5A, 64'd0, 64'd0, 64'd0, 64'h1);
		byte_buf = '{8'h5A};
		send_buffer();
		settle();

		// nothing compared
		set_config(64'd2, '1, '1, '1, '1, 64'd0);
		byte_buf = '{8'h00, 8'hFF};
		send_buffer();
		settle();

		// don't care in the middle, bytes after the hit are dropped
		set_config(64'd5, 64'h0000_0005_0403_0201, '1, '1, '1, 64'h1B);
		byte_buf = '{8'hFF, 8'h01, 8'h02, 8'h77, 8'h04, 8'h05, 8'h09};
		send_buffer();
		byte_buf = '{8'h01, 8'h02, 8'h03, 8'h04};
		send_buffer();
		settle();

		while (live_bytes < N_ITEMS) begin
			idle_in = ($urandom_range(0, 3) != 0);
			idle_out = ($urandom_range(0, 3) != 0);
			len_v = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0: len_v[5:0] = 6'd0;
				1: len_v[5:0] = 6'd1;
				2: len_v[5:0] = 6'd32;
				3: len_v[5:0] = $urandom_range(33, 63);
				4: len_v[5:0] = $urandom_range(9, 31);
				default: len_v[5:0] = $urandom_range(2, 8);
			endcase
			foreach (pw[i]) pw[i] = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
			mask_v = {$urandom, $urandom};
			case ($urandom_range(0, 5))
				0: mask_v[31:0] = '0;
				1: mask_v[31:0] = $urandom;
				2: mask_v[31:0] = ~(32'h1 << $urandom_range(0, 31));
				default: mask_v[31:0] = '1;
			endcase
			set_config(len_v, pw[0], pw[1], pw[2], pw[3], mask_v);

			repeat ($urandom_range(3, 8)) begin
				len = sb.eff_len();
				blen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 70) : $urandom_range(1, len + 6);
				byte_buf.delete();
				repeat (blen) byte_buf.push_back($urandom_range(0, 255));
				if ($urandom_range(0, 4) != 0) begin
					pos = $urandom_range(0, blen - 1);
					for (int i = 0; i < len && pos + i < blen; i++)
						if (sb.byte_mask[i]) byte_buf[pos + i] = sb.pattern_byte(i);
					if ($urandom_range(0, 5) == 0) begin
						pos = pos + $urandom_range(0, len - 1);
						if (pos < blen) byte_buf[pos] = ~byte_buf[pos];
					end
				end
				send_buffer();
			end
			settle();
		end

		settle();
		if (sb.errors == 0 && sb.hits_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/mbps_pkg.sv
sv/mbps_cell.sv
sv/mbps_out_buf.sv
sv/masked_byte_pattern_search_core.sv
tb/sv/tb_top.sv
